FILE: design/hstd_pkg.sv
// hstd_pkg: widths, reciprocal constants, the shared multiplier request type
// and the cumulative month table for the hours-to-date converter
// no dependencies
package hstd_pkg;

  localparam int HC_W   = 31;
  localparam int YEAR_W = 18;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int HR_W   = 5;

  // day numbers reach hours / 24 + 1, below 2**27
  localparam int JD_W   = 27;
  localparam int DOY_W  = 9;
  localparam int Q100_W = 12;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 28;
  localparam int PROD_W = 2 * MUL_W;

  // x / 3 for x < 2**28 as (x * K) >> 29
  localparam logic [MUL_W-1:0] K_DIV3   = 28'd178956971;
  localparam int               DIV3_SH  = 29;
  // years elapsed estimate: jd * 400 / 146097 as (jd * K) >> 32
  localparam logic [MUL_W-1:0] K_EST    = 28'd11759221;
  localparam int               EST_SH   = 32;
  // y / 100 for y < 2**18 as (y * K) >> 26
  localparam logic [MUL_W-1:0] K_DIV100 = 28'd671089;
  localparam int               DIV100_SH = 26;

  localparam logic [DOY_W-1:0]  DAYS_PER_YEAR    = 9'd365;
  localparam logic [DOY_W-1:0]  DAYS_IN_JAN      = 9'd31;
  localparam logic [YEAR_W-1:0] BASE_YEAR        = 18'd1900;
  localparam logic [JD_W:0]     DAYS_BEFORE_BASE = 28'd693960;

  typedef struct packed {
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // days in the months before month idx + 1 of a common year
  function automatic logic [DOY_W-1:0] cum_days(input logic [MON_W-1:0] idx);
    logic [DOY_W-1:0] d;
    case (idx)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

FILE: design/hstd_if.sv
// hstd_in_if / hstd_out_if: valid-ready channels of the hours-to-date converter
// depends on hstd_pkg for the field widths
interface hstd_in_if;
  logic                           valid;
  logic                           ready;
  logic [hstd_pkg::HC_W-1:0]      hour_count;

  modport source (output valid, output hour_count, input ready);
  modport sink   (input valid, input hour_count, output ready);
endinterface

interface hstd_out_if;
  logic                           valid;
  logic                           ready;
  logic [hstd_pkg::YEAR_W-1:0]    cal_year;
  logic [hstd_pkg::MON_W-1:0]     cal_month;
  logic [hstd_pkg::DAY_W-1:0]     cal_day;
  logic [hstd_pkg::HR_W-1:0]      hour_of_day;

  modport source (output valid, output cal_year, output cal_month, output cal_day,
                  output hour_of_day, input ready);
  modport sink   (input valid, input cal_year, input cal_month, input cal_day,
                  input hour_of_day, output ready);
endinterface

FILE: design/hours_since_1900_to_date_core.sv
// channel   dir  handshake     word
// in_ch     in   valid/ready   hour_count[30:0]
// out_ch    out  valid/ready   cal_year[17:0] cal_month[3:0] cal_day[4:0] hour_of_day[4:0]
//
// one word at a time: after accept the sequencer runs the divide, the day number, the year
// estimate, the hundreds quotient with the days before the year, and the month decode,
// plus one more pass for each year the estimate is lowered or raised; ready returns
// together with the result valid; the shared multiplier gives one product per step
// rst_n (synchronous) clears the sequencer and the output valid
// a result waiting on out_ch does not block accepting the next word;
// the final step holds until the output register is free
//
// hours_since_1900_to_date_core: top level, sequencer plus shared multiplier
// depends on hstd_pkg, hstd_if, hstd_mul, hstd_ctrl
module hours_since_1900_to_date_core (
  input  logic        clk,
  input  logic        rst_n,
  hstd_in_if.sink     in_ch,
  hstd_out_if.source  out_ch
);
  import hstd_pkg::*;

  mul_req_t          mul_req;
  logic [PROD_W-1:0] mul_prod;

  hstd_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (mul_prod)
  );

  hstd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .mul_req  (mul_req),
    .mul_prod (mul_prod)
  );

endmodule

FILE: design/hstd_mul.sv
// hstd_mul: the shared 28 x 28 unsigned multiplier with a registered product
// depends on hstd_pkg
module hstd_mul (
  input  logic                      clk,
  input  hstd_pkg::mul_req_t        req,
  output logic [hstd_pkg::PROD_W-1:0] prod_r
);
  import hstd_pkg::*;

  logic [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(req.a) * PROD_W'(req.b);

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: design/hstd_ctrl.sv
// hstd_ctrl: sequencer and datapath registers; drives the shared multiplier
// through divide, year estimate and year search, then decodes the month
// depends on hstd_pkg and hstd_if
module hstd_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  hstd_in_if.sink                     in_ch,
  hstd_out_if.source                  out_ch,
  output hstd_pkg::mul_req_t          mul_req,
  input  logic [hstd_pkg::PROD_W-1:0] mul_prod
);
  import hstd_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_DIV  = 11'b00000000010,
    S_JD   = 11'b00000000100,
    S_EST  = 11'b00000001000,
    S_YSET = 11'b00000010000,
    S_CMUL = 11'b00000100000,
    S_CGET = 11'b00001000000,
    S_BASE = 11'b00010000000,
    S_RCHK = 11'b00100000000,
    S_RMUL = 11'b01000000000,
    S_RGET = 11'b10000000000
  } state_t;

  state_t              state_r, state_nxt;
  logic [HC_W-1:0]     hc_r, hc_nxt;
  logic [JD_W-1:0]     jd_r, jd_nxt;
  logic [HR_W-1:0]     hr_r, hr_nxt;
  logic [YEAR_W-1:0]   year_r, year_nxt;
  logic [Q100_W-1:0]   q100_r, q100_nxt;
  logic                leap_r, leap_nxt;
  logic [JD_W-1:0]     day_r, day_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [YEAR_W-1:0]   out_year_r, out_year_nxt;
  logic [MON_W-1:0]    out_month_r, out_month_nxt;
  logic [DAY_W-1:0]    out_day_r, out_day_nxt;
  logic [HR_W-1:0]     out_hour_r, out_hour_nxt;

  logic [JD_W-1:0]     div_q;
  logic [HC_W-1:0]     hr_diff;
  logic [Q100_W-1:0]   q100_new;
  logic [JD_W:0]       before_sum;
  logic                before_lt;
  logic [DOY_W-1:0]    year_len;
  logic [DOY_W-1:0]    doy;
  logic [MON_W-1:0]    mon_sel;
  logic [DOY_W-1:0]    dom;
  logic                out_free;

  // gregorian leap rule from the year and its hundreds quotient
  function automatic logic leap_f(input logic [YEAR_W-1:0] y,
                                  input logic [Q100_W-1:0] q);
    logic [YEAR_W-1:0] q_ext;
    logic [YEAR_W-1:0] r100;
    q_ext = YEAR_W'(q);
    r100  = y - ((q_ext << 6) + (q_ext << 5) + (q_ext << 2));
    return ((y[1:0] == 2'b00) && (r100 != '0)) || ((r100 == '0) && (q[1:0] == 2'b00));
  endfunction

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.cal_year    = out_year_r;
  assign out_ch.cal_month   = out_month_r;
  assign out_ch.cal_day     = out_day_r;
  assign out_ch.hour_of_day = out_hour_r;

  always_comb begin
    state_nxt     = state_r;
    hc_nxt        = hc_r;
    jd_nxt        = jd_r;
    hr_nxt        = hr_r;
    year_nxt      = year_r;
    q100_nxt      = q100_r;
    leap_nxt      = leap_r;
    day_nxt       = day_r;
    out_valid_nxt = out_valid_r;
    out_year_nxt  = out_year_r;
    out_month_nxt = out_month_r;
    out_day_nxt   = out_day_r;
    out_hour_nxt  = out_hour_r;
    mul_req.a     = '0;
    mul_req.b     = '0;

    out_free = !out_valid_r || out_ch.ready;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    // hours / 24 taken as (hours / 8) / 3
    div_q    = mul_prod[DIV3_SH +: JD_W];
    hr_diff  = hc_r - (HC_W'(div_q) << 4) - (HC_W'(div_q) << 3);
    q100_new = mul_prod[DIV100_SH +: Q100_W];

    // days from the base date to jan 1 of year_r; product holds 365 * year
    before_sum = (JD_W+1)'(mul_prod[JD_W-1:0]) + (JD_W+1)'(year_r >> 2)
               - (JD_W+1)'(q100_r) + (JD_W+1)'(q100_r >> 2)
               - DAYS_BEFORE_BASE - (JD_W+1)'(leap_r);
    before_lt  = before_sum[JD_W-1:0] < jd_r;

    year_len = DAYS_PER_YEAR + DOY_W'(leap_r);

    // month decode, the smallest month whose end covers the day of year
    doy     = day_r[DOY_W-1:0];
    mon_sel = MON_W'(12);
    for (int m = 11; m >= 2; m--) begin
      if (doy <= cum_days(MON_W'(m)) + DOY_W'(leap_r)) begin
        mon_sel = MON_W'(m);
      end
    end
    if (doy <= DAYS_IN_JAN) begin
      mon_sel = MON_W'(1);
    end
    dom = doy - cum_days(mon_sel - MON_W'(1))
        - ((mon_sel >= MON_W'(3)) ? DOY_W'(leap_r) : DOY_W'(0));

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          hc_nxt    = in_ch.hour_count;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        mul_req.a = hc_r[HC_W-1:3];
        mul_req.b = K_DIV3;
        state_nxt = S_JD;
      end
      S_JD: begin
        jd_nxt    = div_q + JD_W'(1);
        hr_nxt    = hr_diff[HR_W-1:0];
        state_nxt = S_EST;
      end
      S_EST: begin
        mul_req.a = MUL_W'(jd_r);
        mul_req.b = K_EST;
        state_nxt = S_YSET;
      end
      S_YSET: begin
        year_nxt  = mul_prod[EST_SH +: YEAR_W] + BASE_YEAR;
        state_nxt = S_CMUL;
      end
      S_CMUL: begin
        mul_req.a = MUL_W'(year_r);
        mul_req.b = K_DIV100;
        state_nxt = S_CGET;
      end
      S_CGET: begin
        q100_nxt  = q100_new;
        leap_nxt  = leap_f(year_r, q100_new);
        mul_req.a = MUL_W'(year_r);
        mul_req.b = MUL_W'(DAYS_PER_YEAR);
        state_nxt = S_BASE;
      end
      S_BASE: begin
        if (before_lt || (year_r <= BASE_YEAR)) begin
          day_nxt   = jd_r - before_sum[JD_W-1:0];
          state_nxt = S_RCHK;
        end else begin
          year_nxt  = year_r - YEAR_W'(1);
          state_nxt = S_CMUL;
        end
      end
      S_RCHK: begin
        if (day_r > JD_W'(year_len)) begin
          day_nxt   = day_r - JD_W'(year_len);
          year_nxt  = year_r + YEAR_W'(1);
          state_nxt = S_RMUL;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_year_nxt  = year_r;
          out_month_nxt = mon_sel;
          out_day_nxt   = dom[DAY_W-1:0];
          out_hour_nxt  = hr_r;
          state_nxt     = S_IDLE;
        end
      end
      S_RMUL: begin
        mul_req.a = MUL_W'(year_r);
        mul_req.b = K_DIV100;
        state_nxt = S_RGET;
      end
      S_RGET: begin
        q100_nxt  = q100_new;
        leap_nxt  = leap_f(year_r, q100_new);
        state_nxt = S_RCHK;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hc_r        <= hc_nxt;
    jd_r        <= jd_nxt;
    hr_r        <= hr_nxt;
    year_r      <= year_nxt;
    q100_r      <= q100_nxt;
    leap_r      <= leap_nxt;
    day_r       <= day_nxt;
    out_year_r  <= out_year_nxt;
    out_month_r <= out_month_nxt;
    out_day_r   <= out_day_nxt;
    out_hour_r  <= out_hour_nxt;
  end

endmodule

FILE: design/hstd_checker.sv
// hstd_checker: port-level assertions on the hours-to-date converter
// and the bind that attaches it to hours_since_1900_to_date_core
module hstd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [17:0] cal_year,
  input logic [3:0]  cal_month,
  input logic [4:0]  cal_day,
  input logic [4:0]  hour_of_day
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(cal_year) && $stable(cal_month)
      && $stable(cal_day) && $stable(hour_of_day))
    else $error("result word changed while stalled");

  // busy right after taking a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accept");

  // a fresh result only comes out of a busy conversion
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without a conversion in flight");

  // every result has month 1 to 12, day at least 1, hour up to 23, year from 1900
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1
      && hour_of_day <= 5'd23 && cal_year >= 18'd1900)
    else $error("result field out of range");

endmodule

bind hours_since_1900_to_date_core hstd_checker u_hstd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .cal_year    (out_ch.cal_year),
  .cal_month   (out_ch.cal_month),
  .cal_day     (out_ch.cal_day),
  .hour_of_day (out_ch.hour_of_day)
);

FILE: verif/testbench.sv
// testbench for hours_since_1900_to_date_core: hour counts in, calendar dates out,
// each result checked against a calendar predictor held in this file
// depends on hstd_pkg, hstd_if and the design files
`timescale 1ns / 100ps

module testbench;
  import hstd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS = 10;
  localparam int unsigned MONTH_START [12] =
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  typedef struct packed {
    logic [YEAR_W-1:0] year;
    logic [MON_W-1:0]  month;
    logic [DAY_W-1:0]  day;
    logic [HR_W-1:0]   hour;
  } cal_date_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   snd_idle_pct = 0;
  int   rcv_idle_pct = 0;
  int   error_count = 0;
  int   cycle_count = 0;
  cal_date_t expected_dates [$];

  hstd_in_if  in_ch ();
  hstd_out_if out_ch ();

  hours_since_1900_to_date_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  function automatic int unsigned is_leap_year(input longint unsigned y);
    if ((y % 4) == 0 && (y % 100) != 0) return 1;
    if ((y % 400) == 0) return 1;
    return 0;
  endfunction

  // days from 1900-01-01 to jan 1 of year y
  function automatic longint unsigned days_to_year(input longint unsigned y);
    longint unsigned t;
    t = 365 * y + y / 4 - y / 100 + y / 400;
    return t - 693960 - is_leap_year(y);
  endfunction

  function automatic cal_date_t hours_to_date(input logic [HC_W-1:0] hc);
    longint unsigned day_num;
    longint unsigned yr;
    longint unsigned ydays;
    longint unsigned doy;
    int unsigned     lp;
    int unsigned     mon;
    int unsigned     i;
    cal_date_t       r;
    day_num = {33'd0, hc} / 24 + 1;
    yr = (day_num * 400) / 146097 + 1900;
    ydays = days_to_year(yr);
    // pull the estimate down until the earlier years hold fewer days
    while (ydays >= day_num && yr > 1900) begin
      yr--;
      ydays = days_to_year(yr);
    end
    lp = is_leap_year(yr);
    doy = day_num - ydays;
    while (doy > 365 + lp) begin
      doy -= 365 + lp;
      yr++;
      lp = is_leap_year(yr);
    end
    mon = 12;
    if (doy <= 31) begin
      mon = 1;
    end else begin
      i = 3;
      while (i <= 12) begin
        if (doy <= MONTH_START[i-1] + lp) begin
          mon = i - 1;
          i = 13;
        end else begin
          i++;
        end
      end
    end
    doy -= MONTH_START[mon-1];
    if (mon >= 3) doy -= lp;
    r.year  = yr[YEAR_W-1:0];
    r.month = mon[MON_W-1:0];
    r.day   = doy[DAY_W-1:0];
    r.hour  = HR_W'({33'd0, hc} % 24);
    return r;
  endfunction

  function automatic logic [HC_W-1:0] date_to_hours(input int unsigned y, input int unsigned m,
                                                   input int unsigned d, input int unsigned h);
    longint unsigned dn;
    dn = days_to_year(y) + MONTH_START[m-1] + ((m >= 3) ? is_leap_year(y) : 0) + d - 1;
    return HC_W'(dn * 24 + h);
  endfunction

  // hold the word until accepted, expectation queued at the accepting edge
  task automatic send_hours(input logic [HC_W-1:0] hc);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.hour_count <= hc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_dates.push_back(hours_to_date(hc));
  endtask

  // result side: random stalls, compare against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cal_date_t got;
    cal_date_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cal_year, out_ch.cal_month, out_ch.cal_day, out_ch.hour_of_day};
      if (expected_dates.size() == 0) begin
        if (error_count < MAX_REPORTS)
          $display("unexpected result: year %0d month %0d day %0d hour %0d",
                   got.year, got.month, got.day, got.hour);
        error_count++;
      end else begin
        want = expected_dates.pop_front();
        if (got !== want) begin
          if (error_count < MAX_REPORTS)
            $display("mismatch: expected %0d-%0d-%0d h%0d, got %0d-%0d-%0d h%0d",
                     want.year, want.month, want.day, want.hour,
                     got.year, got.month, got.day, got.hour);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // field extremes, leap rules around century years, year turnovers
  task automatic test_directed();
    send_hours('0);
    send_hours(31'd23);
    send_hours(31'd24);
    send_hours(31'h7FFF_FFFF);
    send_hours(31'h2AAA_AAAA);
    send_hours(31'h5555_5555);
    send_hours(date_to_hours(1900, 2, 28, 23));
    send_hours(date_to_hours(1900, 3, 1, 0));
    send_hours(date_to_hours(1900, 12, 31, 23));
    send_hours(date_to_hours(1901, 1, 1, 0));
    send_hours(date_to_hours(1904, 2, 29, 12));
    send_hours(date_to_hours(1904, 3, 1, 0));
    send_hours(date_to_hours(1999, 12, 31, 23));
    send_hours(date_to_hours(2000, 1, 1, 0));
    send_hours(date_to_hours(2000, 2, 29, 5));
    send_hours(date_to_hours(2000, 12, 31, 23));
    send_hours(date_to_hours(2100, 2, 28, 23));
    send_hours(date_to_hours(2100, 3, 1, 0));
    send_hours(date_to_hours(2400, 2, 29, 7));
    send_hours(date_to_hours(123456, 6, 15, 12));
    send_hours(date_to_hours(246882, 12, 31, 23));
  endtask

  task automatic test_random_full(input int count);
    repeat (count) send_hours(HC_W'($urandom));
  endtask

  // dates right at year and february edges, century years weighted up
  task automatic test_year_edges(input int count);
    int unsigned y;
    int unsigned h;
    repeat (count) begin
      if ($urandom_range(3) == 0) y = 100 * $urandom_range(19, 2468);
      else y = $urandom_range(1900, 246882);
      h = $urandom_range(23);
      case ($urandom_range(4))
        0: send_hours(date_to_hours(y, 12, 31, h));
        1: send_hours(date_to_hours(y, 1, 1, h));
        2: send_hours(date_to_hours(y, 2, 28, h));
        3: send_hours(date_to_hours(y, 2, 28 + is_leap_year(y), h));
        default: send_hours(date_to_hours(y, 3, 1, h));
      endcase
    end
  endtask

  task automatic test_random_mixed(input int count);
    repeat (count) begin
      case ($urandom_range(3))
        0: send_hours(HC_W'($urandom));
        1: send_hours(HC_W'($urandom_range(0, 24 * 800)));
        2: send_hours(HC_W'(32'h7FFF_FFFF - $urandom_range(0, 24 * 800)));
        default: send_hours(date_to_hours($urandom_range(1900, 246882), $urandom_range(1, 12),
                                          $urandom_range(1, 28), $urandom_range(23)));
      endcase
    end
  endtask

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.hour_count <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    snd_idle_pct = 20;
    rcv_idle_pct = 63;
    test_directed();
    test_random_full(350);

    snd_idle_pct = 63;
    rcv_idle_pct = 20;
    test_year_edges(350);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    test_random_mixed(330);

    in_ch.valid <= 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
